/* hw/rtl/nelw_pkg.sv */
// shared types and constants for the nonprintable escape / line wrap block
// depends on nothing; used by every module of the block
package nelw_pkg;

  localparam int MaxChars = 6;
  localparam int CntW = 3;
  localparam int DefQueueDepth = 2;

  localparam logic [7:0] ResetLineLimit = 8'd70;
  localparam logic [7:0] ChNewline = 8'h0a;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChX = 8'h78;
  localparam logic [7:0] ChTilde = 8'h7e;

  localparam logic [0:0] RegEscapeMode = 1'b0;
  localparam logic [0:0] RegLineLimit = 1'b1;

  localparam logic ModeOctal = 1'b0;

  typedef struct packed {
    logic [MaxChars-1:0][7:0] chars;
    logic [CntW-1:0] cnt;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] d);
    logic [7:0] r;
    if (d < 4'd10) begin
      r = 8'h30 + {4'b0, d};
    end else begin
      r = 8'h61 + {4'b0, d} - 8'd10;
    end
    return r;
  endfunction

endpackage

/* hw/rtl/nelw_front.sv */
// front end: config registers, byte classification, escape expansion, column count
// depends on nelw_pkg
module nelw_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_addr,
  input  logic [7:0]          cfg_wdata,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,
  input  nelw_pkg::queue_status_t q_status,
  output logic                q_push,
  output nelw_pkg::entry_t    q_wdata
);

  logic       mode_r;
  logic [7:0] limit_r;
  logic [8:0] col_r, col_nxt;
  logic       printable;
  logic [2:0] n;
  logic [8:0] sum;
  logic       wrap;
  logic [7:0] d2, d1, d0, hi, lo;

  assign in_tready = !q_status.full;
  assign q_push = in_tvalid && in_tready;

  always_comb begin
    printable = (in_tdata >= nelw_pkg::ChSpace) && (in_tdata <= nelw_pkg::ChTilde);
    d2 = nelw_pkg::ChZero + {6'b0, in_tdata[7:6]};
    d1 = nelw_pkg::ChZero + {5'b0, in_tdata[5:3]};
    d0 = nelw_pkg::ChZero + {5'b0, in_tdata[2:0]};
    hi = nelw_pkg::hex_digit(in_tdata[7:4]);
    lo = nelw_pkg::hex_digit(in_tdata[3:0]);
    q_wdata.chars = {nelw_pkg::MaxChars{nelw_pkg::ChSpace}};
    if (printable) begin
      q_wdata.chars[0] = in_tdata;
      n = 3'd1;
    end else if (mode_r == nelw_pkg::ModeOctal) begin
      q_wdata.chars[0] = nelw_pkg::ChZero;
      if (in_tdata >= 8'd64) begin
        q_wdata.chars[1] = d2;
        q_wdata.chars[2] = d1;
        q_wdata.chars[3] = d0;
      end else if (in_tdata >= 8'd8) begin
        q_wdata.chars[1] = d1;
        q_wdata.chars[2] = d0;
      end else begin
        q_wdata.chars[1] = d0;
      end
      n = 3'd5;
    end else begin
      q_wdata.chars[0] = nelw_pkg::ChZero;
      q_wdata.chars[1] = nelw_pkg::ChX;
      if (in_tdata >= 8'd16) begin
        q_wdata.chars[2] = hi;
        q_wdata.chars[3] = lo;
        n = 3'd5;
      end else begin
        q_wdata.chars[2] = lo;
        n = 3'd4;
      end
    end
    sum = col_r + {6'b0, n};
    wrap = sum >= {1'b0, limit_r};
    // newline goes right after the byte's characters
    if (wrap) begin
      q_wdata.chars[n] = nelw_pkg::ChNewline;
      q_wdata.cnt = n + 3'd1;
    end else begin
      q_wdata.cnt = n;
    end
    col_nxt = col_r;
    if (q_push) begin
      col_nxt = wrap ? 9'd0 : sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= nelw_pkg::ModeOctal;
      limit_r <= nelw_pkg::ResetLineLimit;
      col_r <= 9'd0;
    end else begin
      col_r <= col_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          nelw_pkg::RegEscapeMode: mode_r <= cfg_wdata[0];
          nelw_pkg::RegLineLimit: limit_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

endmodule

/* hw/rtl/nelw_queue.sv */
// short queue of expanded entries between front and back
// depends on nelw_pkg
module nelw_queue #(
  parameter int Depth = nelw_pkg::DefQueueDepth
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  nelw_pkg::entry_t        wdata,
  input  logic                    pop,
  output nelw_pkg::entry_t        rdata,
  output nelw_pkg::queue_status_t status
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CountW = $clog2(Depth + 1);

  nelw_pkg::entry_t mem_r [Depth];
  logic [PtrW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CountW-1:0] count_r;

  assign status.full = count_r == CountW'(Depth);
  assign status.empty = count_r == '0;
  assign rdata = mem_r[rd_ptr_r];

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (push) wr_ptr_r <= bump(wr_ptr_r);
      if (pop) rd_ptr_r <= bump(rd_ptr_r);
      if (push && !pop) count_r <= count_r + CountW'(1);
      else if (pop && !push) count_r <= count_r - CountW'(1);
    end
  end

endmodule

/* hw/rtl/nelw_back.sv */
// back end: walks one entry a character at a time into the output register
// depends on nelw_pkg
module nelw_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  nelw_pkg::queue_status_t q_status,
  input  nelw_pkg::entry_t        q_rdata,
  output logic                    q_pop,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [7:0]              out_tdata,
  output logic                    out_tlast
);

  logic [nelw_pkg::CntW-1:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] char_r, char_nxt;
  logic       last_r, last_nxt;
  logic       load, take, at_end;

  assign out_tvalid = valid_r;
  assign out_tdata = char_r;
  assign out_tlast = last_r;

  always_comb begin
    load = !valid_r || out_tready;
    take = load && !q_status.empty;
    at_end = idx_r == (q_rdata.cnt - nelw_pkg::CntW'(1));
    q_pop = take && at_end;
    idx_nxt = idx_r;
    valid_nxt = valid_r;
    char_nxt = char_r;
    last_nxt = last_r;
    if (load) valid_nxt = take;
    if (take) begin
      char_nxt = q_rdata.chars[idx_r];
      last_nxt = at_end;
      idx_nxt = at_end ? '0 : idx_r + nelw_pkg::CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

endmodule

/* hw/rtl/nonprintable_escape_line_wrap_unit.sv */
// top level of the nonprintable byte escaper with line wrap
// depends on nelw_pkg, nelw_front, nelw_queue, nelw_back
//
// usage:
// - in_* stream carries raw bytes; out_* stream carries ascii characters,
//   out_tlast high on the final character of each byte (the newline if one
//   is appended)
// - cfg port: index 0 escape mode (0 octal, 1 hex), index 1 line limit;
//   write only while the block is idle
// - a byte expands to 1 to 6 characters, sent one per cycle while the queue
//   holds an entry and the receiver is ready; the single output register of
//   the back end sets that rate
// - an accepted byte is first written into a queue entry, then its first
//   character is loaded into the output register of the back end
// - the front expands bytes into a QueueDepth-entry queue, so input keeps
//   flowing while the output register holds a character
// - receiver stall: the output holds, the queue fills, then in_tready drops
// - reset: mode octal, limit 70, column count zero, queue and output empty
module nonprintable_escape_line_wrap_unit #(
  parameter int QueueDepth = nelw_pkg::DefQueueDepth
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [0:0] cfg_addr,
  input  logic [7:0] cfg_wdata,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic       out_tlast   // last_char
);

  nelw_pkg::queue_status_t q_status;
  nelw_pkg::entry_t        q_wdata, q_rdata;
  logic                    q_push, q_pop;

  // classify and expand each byte, track the column
  nelw_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .q_status (q_status),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  // decouples the two sides
  nelw_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .status(q_status)
  );

  // serialize characters onto the output stream
  nelw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

endmodule

/* tb/nelw_char_checker.sv */
// checker for nonprintable_escape_line_wrap_unit: watches the cfg, in_ and out_ ports,
// predicts the characters of every accepted byte and compares them in order
// depends on nelw_pkg for register indexes, mode code and character constants
module nelw_char_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  input  logic        out_tlast,
  output int unsigned fail_count,
  output int unsigned pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_last;
  } want_t;

  want_t      want_chars [$];
  logic       esc_mode;
  logic [7:0] wrap_limit;
  logic [8:0] col_count;

  initial begin
    fail_count = 0;
    pending = 0;
    esc_mode = nelw_pkg::ModeOctal;
    wrap_limit = nelw_pkg::ResetLineLimit;
    col_count = '0;
  end

  function automatic logic [7:0] nibble_char(input logic [3:0] d);
    return (d > 4'd9) ? (8'h57 + {4'd0, d}) : (nelw_pkg::ChZero + {4'd0, d});
  endfunction

  // expand one byte into its characters, newline included when the line fills
  task automatic predict_byte(input logic [7:0] b);
    logic [7:0] seq [0:5];
    int n;
    int k;
    want_t w;
    n = 0;
    if (b >= nelw_pkg::ChSpace && b <= nelw_pkg::ChTilde) begin
      seq[0] = b;
      n = 1;
    end else if (esc_mode == nelw_pkg::ModeOctal) begin
      seq[0] = nelw_pkg::ChZero;
      n = 1;
      if (b >= 8'd64) begin
        seq[n] = nelw_pkg::ChZero + {6'd0, b[7:6]};
        n++;
      end
      if (b >= 8'd8) begin
        seq[n] = nelw_pkg::ChZero + {5'd0, b[5:3]};
        n++;
      end
      seq[n] = nelw_pkg::ChZero + {5'd0, b[2:0]};
      n++;
      // digit field is always three wide, padded on the right
      while (n < 4) begin
        seq[n] = nelw_pkg::ChSpace;
        n++;
      end
      seq[n] = nelw_pkg::ChSpace;
      n++;
    end else begin
      seq[0] = nelw_pkg::ChZero;
      seq[1] = nelw_pkg::ChX;
      n = 2;
      if (b >= 8'd16) begin
        seq[n] = nibble_char(b[7:4]);
        n++;
      end
      seq[n] = nibble_char(b[3:0]);
      n++;
      seq[n] = nelw_pkg::ChSpace;
      n++;
    end
    col_count = col_count + n[8:0];
    if (col_count >= {1'b0, wrap_limit}) begin
      seq[n] = nelw_pkg::ChNewline;
      n++;
      col_count = '0;
    end
    for (k = 0; k < n; k++) begin
      w.ch = seq[k];
      w.is_last = (k == n - 1);
      want_chars.push_back(w);
    end
  endtask

  always @(posedge clk) begin : watch_ports
    want_t w;
    if (!rst_n) begin
      want_chars.delete();
      esc_mode = nelw_pkg::ModeOctal;
      wrap_limit = nelw_pkg::ResetLineLimit;
      col_count = '0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == nelw_pkg::RegEscapeMode) begin
          esc_mode = cfg_wdata[0];
        end else if (cfg_addr == nelw_pkg::RegLineLimit) begin
          wrap_limit = cfg_wdata;
        end
      end
      // predict before comparing so a same-edge pass-through still lines up
      if (in_tvalid && in_tready) begin
        predict_byte(in_tdata);
      end
      if (out_tvalid && out_tready) begin
        if (want_chars.size() == 0) begin
          $error("out_char: expected none, actual %02h", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          w = want_chars.pop_front();
          if (out_tdata !== w.ch || out_tlast !== w.is_last) begin
            fail_count <= fail_count + 1;
          end
          if (out_tdata !== w.ch) begin
            $error("out_char: expected %02h, actual %02h", w.ch, out_tdata);
          end
          if (out_tlast !== w.is_last) begin
            $error("last_char: expected %0b, actual %0b", w.is_last, out_tlast);
          end
        end
      end
    end
    pending <= want_chars.size();
  end

endmodule

/* tb/tb_nonprintable_escape_line_wrap_unit.sv */
// top of the testbench for nonprintable_escape_line_wrap_unit: clock, reset,
// byte stimulus in bursts, receiver stalls, register phases and the verdict
// depends on nelw_pkg, the block itself and nelw_char_checker
module tb_nonprintable_escape_line_wrap_unit;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [0:0]  cfg_addr;
  logic [7:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // [7:0] in_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;   // [7:0] out_char
  logic        out_tlast;   // last_char
  int unsigned fail_count;
  int unsigned pending;

  // sender burst bookkeeping
  int unsigned burst_left = 0;

  // receiver stall pattern state
  int unsigned stall_kind = 0;
  int unsigned stall_left = 0;

  nonprintable_escape_line_wrap_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  nelw_char_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 20 ns clock
  initial begin
    forever #10 clk = ~clk;
  end

  // receiver: stretches of always-ready, coin-flip, mostly-stalled and periodic
  // back-pressure, each of random length
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_kind <= $urandom_range(0, 3);
      stall_left <= $urandom_range(10, 120);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_kind)
      0: begin
        out_tready <= 1'b1;
      end
      1: begin
        out_tready <= 1'($urandom_range(0, 1));
      end
      2: begin
        out_tready <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        out_tready <= (stall_left[2:0] != 3'd0);
      end
    endcase
  end

  // random byte: a mix of full range, printable and control/high bytes
  function automatic logic [7:0] pick_byte();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      return 8'($urandom_range(0, 255));
    end else if (sel < 7) begin
      return 8'($urandom_range(32, 126));
    end else if ($urandom_range(0, 1) == 0) begin
      return 8'($urandom_range(0, 31));
    end
    return 8'($urandom_range(127, 255));
  endfunction

  // one byte request; opens a new burst after a random gap when the last
  // burst is used up, keeps in_tvalid high inside a burst
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(1, 10);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tdata <= b;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  // stop sending and wait until every predicted character has come out
  task automatic drain_chars();
    in_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
  endtask

  // write both registers back to back; only called while the block is idle
  task automatic set_regs(input logic [7:0] mode_data, input logic [7:0] limit_data);
    cfg_we <= 1'b1;
    cfg_addr <= nelw_pkg::RegEscapeMode;
    cfg_wdata <= mode_data;
    @(posedge clk);
    cfg_addr <= nelw_pkg::RegLineLimit;
    cfg_wdata <= limit_data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input logic [7:0] mode_data, input logic [7:0] limit_data,
                            input int unsigned count);
    int unsigned i;
    set_regs(mode_data, limit_data);
    for (i = 0; i < count; i++) begin
      send_byte(pick_byte());
    end
    drain_chars();
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_addr <= nelw_pkg::RegEscapeMode;
    cfg_wdata <= 8'h00;
    in_tvalid <= 1'b0;
    in_tdata <= 8'h00;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: octal escapes, limit 70; range edges of the printable
    // window, zero byte, newline input, top bit set
    send_byte(8'h00);
    send_byte(8'h07);
    send_byte(8'h08);
    send_byte(8'h0a);
    send_byte(8'h1f);
    send_byte(8'h20);
    send_byte(8'h3f);
    send_byte(8'h40);
    send_byte(8'h7e);
    send_byte(8'h7f);
    send_byte(8'h80);
    send_byte(8'hff);
    drain_chars();

    // hex escapes with a zero limit: newline after every byte
    set_regs(8'h01, 8'd0);
    send_byte(8'h00);
    send_byte(8'h0f);
    send_byte(8'h10);
    send_byte(8'hff);
    send_byte(8'h41);
    drain_chars();

    // upper mode bits are masked off, so this is octal; limit below five
    set_regs(8'hfe, 8'd4);
    send_byte(8'h41);
    send_byte(8'h00);
    send_byte(8'hab);
    drain_chars();

    set_regs(8'h01, 8'd1);
    send_byte(8'h5a);
    send_byte(8'h9c);
    drain_chars();

    // random phases; the widest limit lets the line grow long, and the
    // following lower limit makes the first byte wrap at once
    run_random(8'h01, 8'd255, 35);
    run_random(8'h00, 8'd13, 25);
    run_random(8'hff, 8'd5, 20);
    run_random(8'h00, 8'd70, 25);
    run_random(8'h00, 8'd200, 25);
    run_random(8'h01, 8'd9, 18);

    // let anything still in flight show up before the verdict
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // overall limit, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
